[src/ipd_pkg.sv]
// shared constants for the +IPD mqtt publish deframer
package ipd_pkg;

  localparam int unsigned HdrLen = 5;

  typedef logic [1:0] kind_t;

  localparam kind_t KindTopic   = 2'd0;
  localparam kind_t KindPayload = 2'd1;
  localparam kind_t KindEmpty   = 2'd2;
  localparam kind_t KindReject  = 2'd3;

  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] MqttPubQ0 = 8'h30;

  localparam logic [0:0] CfgMaxTopic   = 1'b0;
  localparam logic [0:0] CfgMaxPayload = 1'b1;

  localparam logic [6:0] MaxTopicRst   = 7'd64;
  localparam logic [7:0] MaxPayloadRst = 8'd128;

  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h2B;
      3'd1:    c = 8'h49;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h44;
      3'd4:    c = 8'h2C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[src/at_ipd_mqtt_publish_deframer.sv]
// +IPD frame deframer that streams topic and payload bytes of mqtt publish packets
// a result beat is registered and appears in the cycle after the byte that causes it is accepted
// throughput: one rx byte per cycle; the single output register holds off input only
//   while a result waits and out_stall_i is high
// reset: hunting for the header, limits back to 64 topic and 128 payload bytes
module at_ipd_mqtt_publish_deframer #(
  parameter int unsigned MAX_FRAME_LEN = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] data_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  typedef enum logic [3:0] {
    PhHunt    = 4'd0,
    PhLen     = 4'd1,
    PhFirst   = 4'd2,
    PhVarint  = 4'd3,
    PhTlenHi  = 4'd4,
    PhTlenLo  = 4'd5,
    PhTopic   = 4'd6,
    PhPayload = 4'd7,
    PhSkip    = 4'd8
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  pos_q, pos_d;
  logic [15:0] fl_q, fl_d;
  logic [15:0] fp_q, fp_d;
  logic [27:0] rl_q, rl_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [15:0] tl_q, tl_d;
  logic [15:0] pl_q, pl_d;
  logic [6:0]  max_topic_q;
  logic [7:0]  max_payload_q;
  logic        out_valid_q;
  ipd_pkg::kind_t kind_q;
  logic [7:0]  data_q;
  logic        last_q;

  logic        accept;
  logic [7:0]  b;
  logic        emit;
  ipd_pkg::kind_t emit_kind;
  logic [7:0]  emit_data;
  logic        emit_last;
  logic        reject;
  logic        in_frame;
  logic        do_hunt;
  logic [2:0]  hunt_pos;
  logic        hunt_hit;
  logic        is_digit;
  logic [19:0] len_v;
  logic [15:0] fp_n;
  logic [27:0] vshift;
  logic [2:0]  cnt_n;
  logic [15:0] tl_full;
  logic [15:0] pl_calc;
  logic [16:0] hdr_tl;
  logic [17:0] hdr_tl_pl;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign data_o      = data_q;
  assign last_o      = last_q;

  assign b        = rx_byte_i;
  assign is_digit = (b >= ipd_pkg::ChZero) && (b <= ipd_pkg::ChNine);
  assign len_v    = ({4'd0, fl_q} << 3) + ({4'd0, fl_q} << 1) + {12'd0, b - ipd_pkg::ChZero};
  assign fp_n     = fp_q + 16'd1;
  assign cnt_n    = cnt_q + 3'd1;
  assign tl_full  = {tl_q[15:8], b};
  assign pl_calc  = rl_q[15:0] - 16'd2 - tl_full;
  assign hdr_tl   = {1'b0, fp_n} + {1'b0, tl_full};
  assign hdr_tl_pl = {1'b0, hdr_tl} + {2'd0, pl_calc};

  assign hunt_pos = (phase_q == PhLen) ? 3'd0 : pos_q;
  assign hunt_hit = (hunt_pos < 3'(ipd_pkg::HdrLen)) && (b == ipd_pkg::hdr_char(hunt_pos));

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    vshift = {21'd0, b[6:0]};
      2'd1:    vshift = {14'd0, b[6:0], 7'd0};
      2'd2:    vshift = {7'd0, b[6:0], 14'd0};
      default: vshift = {b[6:0], 21'd0};
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    fl_d      = fl_q;
    fp_d      = fp_q;
    rl_d      = rl_q;
    cnt_d     = cnt_q;
    tl_d      = tl_q;
    pl_d      = pl_q;
    emit      = 1'b0;
    emit_kind = ipd_pkg::KindTopic;
    emit_data = 8'd0;
    emit_last = 1'b0;
    reject    = 1'b0;
    in_frame  = 1'b0;
    do_hunt   = 1'b0;

    case (phase_q)
      PhLen: begin
        if (is_digit) begin
          if (len_v > 20'(MAX_FRAME_LEN)) begin
            phase_d = PhHunt;
            pos_d   = 3'd0;
          end else begin
            fl_d = len_v[15:0];
          end
        end else if (b == ipd_pkg::ChColon) begin
          if (fl_q == 16'd0) begin
            phase_d = PhHunt;
            pos_d   = 3'd0;
          end else begin
            phase_d = PhFirst;
            fp_d    = 16'd0;
            rl_d    = 28'd0;
            cnt_d   = 3'd0;
            tl_d    = 16'd0;
            pl_d    = 16'd0;
          end
        end else begin
          phase_d = PhHunt;
          do_hunt = 1'b1;
        end
      end
      PhFirst, PhVarint, PhTlenHi, PhTlenLo, PhTopic, PhPayload, PhSkip: begin
        in_frame = 1'b1;
        fp_d     = fp_n;
        case (phase_q)
          PhFirst: begin
            if (b != ipd_pkg::MqttPubQ0 || fl_q < 16'd2) reject = 1'b1;
            else phase_d = PhVarint;
          end
          PhVarint: begin
            rl_d  = rl_q | vshift;
            cnt_d = cnt_n;
            if (b[7]) begin
              if (cnt_n >= 3'd4 || fp_n >= fl_q) reject = 1'b1;
            end else begin
              if ({1'b0, fp_n} + 17'd2 >= {1'b0, fl_q}) reject = 1'b1;
              else phase_d = PhTlenHi;
            end
          end
          PhTlenHi: begin
            tl_d    = {b, 8'd0};
            phase_d = PhTlenLo;
          end
          PhTlenLo: begin
            tl_d = tl_full;
            if (tl_full > {9'd0, max_topic_q} || hdr_tl >= {1'b0, fl_q}) begin
              reject = 1'b1;
            end else begin
              pl_d = pl_calc;
              if (pl_calc > {8'd0, max_payload_q} || hdr_tl_pl > {2'd0, fl_q}) begin
                reject = 1'b1;
              end else if (tl_full != 16'd0) begin
                phase_d = PhTopic;
              end else if (pl_calc != 16'd0) begin
                phase_d = PhPayload;
              end else begin
                emit      = 1'b1;
                emit_kind = ipd_pkg::KindEmpty;
                emit_last = 1'b1;
                phase_d   = PhSkip;
              end
            end
          end
          PhTopic: begin
            tl_d      = tl_q - 16'd1;
            emit      = 1'b1;
            emit_kind = ipd_pkg::KindTopic;
            emit_data = b;
            if (tl_q == 16'd1) begin
              if (pl_q == 16'd0) begin
                emit_last = 1'b1;
                phase_d   = PhSkip;
              end else begin
                phase_d = PhPayload;
              end
            end
          end
          PhPayload: begin
            pl_d      = pl_q - 16'd1;
            emit      = 1'b1;
            emit_kind = ipd_pkg::KindPayload;
            emit_data = b;
            if (pl_q == 16'd1) begin
              emit_last = 1'b1;
              phase_d   = PhSkip;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        phase_d = PhHunt;
        do_hunt = 1'b1;
      end
    endcase

    if (do_hunt) begin
      if (hunt_hit) begin
        if (hunt_pos == 3'(ipd_pkg::HdrLen - 1)) begin
          phase_d = PhLen;
          fl_d    = 16'd0;
          pos_d   = 3'd0;
        end else begin
          pos_d = hunt_pos + 3'd1;
        end
      end else begin
        pos_d = (b == ipd_pkg::ChPlus) ? 3'd1 : 3'd0;
      end
    end

    if (reject) begin
      emit      = 1'b1;
      emit_kind = ipd_pkg::KindReject;
      emit_data = 8'd0;
      emit_last = 1'b0;
      phase_d   = PhSkip;
    end

    if (in_frame && fp_n >= fl_q) begin
      phase_d = PhHunt;
      pos_d   = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhHunt;
      pos_q         <= 3'd0;
      fl_q          <= 16'd0;
      fp_q          <= 16'd0;
      rl_q          <= 28'd0;
      cnt_q         <= 3'd0;
      tl_q          <= 16'd0;
      pl_q          <= 16'd0;
      max_topic_q   <= ipd_pkg::MaxTopicRst;
      max_payload_q <= ipd_pkg::MaxPayloadRst;
      out_valid_q   <= 1'b0;
      kind_q        <= ipd_pkg::KindTopic;
      data_q        <= 8'd0;
      last_q        <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o && cfg_index_i[1] == 1'b0) begin
        case (cfg_index_i[0])
          ipd_pkg::CfgMaxTopic:   max_topic_q   <= cfg_data_i[6:0];
          ipd_pkg::CfgMaxPayload: max_payload_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (accept) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        fl_q    <= fl_d;
        fp_q    <= fp_d;
        rl_q    <= rl_d;
        cnt_q   <= cnt_d;
        tl_q    <= tl_d;
        pl_q    <= pl_d;
      end
      if (accept && emit) begin
        out_valid_q <= 1'b1;
        kind_q      <= emit_kind;
        data_q      <= emit_data;
        last_q      <= emit_last;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[verif/at_ipd_mqtt_publish_deframer_tb.sv]
// testbench for the +IPD mqtt publish deframer: byte stream in, topic and payload beats out
module at_ipd_mqtt_publish_deframer_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxFrameLen = 4096;
  localparam int unsigned StuckLimit  = 2000;

  typedef enum logic [3:0] {
    PhHunt, PhLen, PhFirst, PhVarint, PhTlenHi, PhTlenLo, PhTopic, PhPayload, PhSkip
  } phase_e;

  typedef struct packed {
    ipd_pkg::kind_t kind;
    logic [7:0]     data;
    logic           last;
  } beat_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] kind_o;
  logic [7:0] data_o;
  logic       last_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  at_ipd_mqtt_publish_deframer #(
    .MAX_FRAME_LEN(MaxFrameLen)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .kind_o     (kind_o),
    .data_o     (data_o),
    .last_o     (last_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // deframer state mirrored from the accepted byte stream
  logic [6:0]  lim_topic;
  logic [7:0]  lim_payload;
  logic [2:0]  hdr_pos;
  phase_e      phase;
  logic [15:0] flen;
  logic [15:0] fpos;
  logic [27:0] rem_len;
  logic [2:0]  vcnt;
  logic [15:0] tlen_left;
  logic [15:0] plen_left;

  beat_t       expected_beats[$];
  beat_t       want;
  logic [7:0]  line_q[$];
  logic        moved;
  logic        idling_on;
  int unsigned mismatches;
  int unsigned stuck_cycles;
  int unsigned sent_bytes;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report(input string what, input int want_v, input int got_v);
    mismatches++;
    $display("%0t: %s expected %0d actual %0d", $time, what, want_v, got_v);
  endtask

  task automatic hunt_step(input logic [7:0] b);
    if (hdr_pos < 5 && b == ipd_pkg::hdr_char(hdr_pos)) begin
      hdr_pos = hdr_pos + 3'd1;
      if (hdr_pos == 3'd5) begin
        phase   = PhLen;
        flen    = '0;
        hdr_pos = '0;
      end
    end else begin
      hdr_pos = (b == ipd_pkg::ChPlus) ? 3'd1 : 3'd0;
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [31:0] acc;
    logic [31:0] hdr;
    logic        rej;
    logic        hit;
    beat_t       res;
    rej = 1'b0;
    hit = 1'b0;
    res = '0;
    if (phase == PhLen) begin
      if (b >= ipd_pkg::ChZero && b <= ipd_pkg::ChNine) begin
        acc = flen * 10 + (b - ipd_pkg::ChZero);
        if (acc > MaxFrameLen) begin
          phase   = PhHunt;
          hdr_pos = '0;
        end else begin
          flen = acc[15:0];
        end
      end else if (b == ipd_pkg::ChColon) begin
        if (flen == 0) begin
          phase   = PhHunt;
          hdr_pos = '0;
        end else begin
          phase     = PhFirst;
          fpos      = '0;
          rem_len   = '0;
          vcnt      = '0;
          tlen_left = '0;
          plen_left = '0;
        end
      end else begin
        phase   = PhHunt;
        hdr_pos = '0;
        hunt_step(b);
      end
    end else if (phase == PhHunt) begin
      hunt_step(b);
    end else begin
      fpos = fpos + 16'd1;
      case (phase)
        PhFirst: begin
          if (b != ipd_pkg::MqttPubQ0 || flen < 2) rej = 1'b1;
          else phase = PhVarint;
        end
        PhVarint: begin
          rem_len = rem_len | (28'(b[6:0]) << (7 * vcnt[1:0]));
          vcnt    = vcnt + 3'd1;
          if (b[7]) begin
            if (vcnt >= 4 || fpos >= flen) rej = 1'b1;
          end else if (32'(fpos) + 2 >= flen) begin
            rej = 1'b1;
          end else begin
            phase = PhTlenHi;
          end
        end
        PhTlenHi: begin
          tlen_left = {b, 8'h00};
          phase     = PhTlenLo;
        end
        PhTlenLo: begin
          hdr            = 32'(fpos);
          tlen_left[7:0] = b;
          if (tlen_left > lim_topic || hdr + tlen_left >= flen) begin
            rej = 1'b1;
          end else begin
            plen_left = 16'(rem_len - 2 - tlen_left);
            if (plen_left > lim_payload || hdr + tlen_left + plen_left > flen) begin
              rej = 1'b1;
            end else if (tlen_left != 0) begin
              phase = PhTopic;
            end else if (plen_left != 0) begin
              phase = PhPayload;
            end else begin
              hit      = 1'b1;
              res.kind = ipd_pkg::KindEmpty;
              res.last = 1'b1;
              phase    = PhSkip;
            end
          end
        end
        PhTopic: begin
          tlen_left = tlen_left - 16'd1;
          hit       = 1'b1;
          res.kind  = ipd_pkg::KindTopic;
          res.data  = b;
          if (tlen_left == 0) begin
            res.last = (plen_left == 0);
            if (plen_left == 0) phase = PhSkip;
            else phase = PhPayload;
          end
        end
        PhPayload: begin
          plen_left = plen_left - 16'd1;
          hit       = 1'b1;
          res.kind  = ipd_pkg::KindPayload;
          res.data  = b;
          if (plen_left == 0) begin
            res.last = 1'b1;
            phase    = PhSkip;
          end
        end
        default: ;
      endcase
      if (rej) begin
        hit   = 1'b1;
        res   = '0;
        res.kind = ipd_pkg::KindReject;
        phase = PhSkip;
      end
      if (fpos >= flen) begin
        phase   = PhHunt;
        hdr_pos = '0;
      end
      if (hit) expected_beats.push_back(res);
    end
  endtask

  // result check, byte prediction, register mirror and watchdog, all at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (expected_beats.size() == 0) begin
          report("unexpected result beat, kind", -1, kind_o);
        end else begin
          want = expected_beats.pop_front();
          if (kind_o != want.kind) report("kind", want.kind, kind_o);
          if (data_o != want.data) report("data", want.data, data_o);
          if (last_o != want.last) report("last", want.last, last_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        deframe_byte(rx_byte_i);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        if (cfg_index_i == 2'(ipd_pkg::CfgMaxTopic)) lim_topic = cfg_data_i[6:0];
        else if (cfg_index_i == 2'(ipd_pkg::CfgMaxPayload)) lim_payload = cfg_data_i;
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= StuckLimit) begin
        $display("%0t: no beat moved for %0d cycles", $time, stuck_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= idling_on && ($urandom_range(99) < 32);
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while (idling_on && $urandom_range(99) < 32) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    sent_bytes++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
    line_q.delete();
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  // header, decimal length and one publish packet, with knobs to break it
  task automatic add_publish(input int tlen, input int plen, input int pad, input int rem_adj,
                             input int len_adj, input logic [7:0] first, input bit wide,
                             input string lead);
    logic [7:0] body[$];
    logic [7:0] vb;
    int         rem;
    int         fl;
    rem = 2 + tlen + plen + rem_adj;
    if (rem < 0) rem = 0;
    body.push_back(first);
    do begin
      vb  = 8'(rem % 128);
      rem = rem / 128;
      if (rem != 0) vb = vb | 8'h80;
      body.push_back(vb);
    end while (rem != 0);
    if (wide) begin
      body[$] = body[$] | 8'h80;
      body.push_back(8'h00);
    end
    body.push_back(8'(tlen >> 8));
    body.push_back(8'(tlen));
    repeat (tlen + plen + pad) body.push_back(8'($urandom_range(255)));
    fl = body.size() + len_adj;
    if (fl < 0) fl = 0;
    put_str({"+IPD,", lead, $sformatf("%0d", fl), ":"});
    foreach (body[i]) line_q.push_back(body[i]);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_burst(input int unsigned budget);
    int unsigned stop;
    int unsigned pick;
    int          tmax;
    int          pmax;
    int          tlen;
    int          plen;
    stop = sent_bytes + budget;
    while (sent_bytes < stop) begin
      pick = $urandom_range(99);
      tmax = (lim_topic < 10) ? lim_topic + 1 : 10;
      pmax = (lim_payload < 16) ? lim_payload + 1 : 16;
      tlen = $urandom_range(tmax);
      plen = $urandom_range(pmax);
      if (pick < 60) begin
        add_publish(tlen, plen, $urandom_range(2), 0, 0, ipd_pkg::MqttPubQ0,
                    $urandom_range(7) == 0, ($urandom_range(9) == 0) ? "0" : "");
      end else if (pick < 62) begin
        add_publish(lim_topic + 1, plen, 1, 0, 0, ipd_pkg::MqttPubQ0, 1'b0, "");
      end else if (pick < 64) begin
        add_publish(tlen, lim_payload + 1, 0, 0, 0, ipd_pkg::MqttPubQ0, 1'b0, "");
      end else if (pick < 80) begin
        add_publish(tlen, plen, $urandom_range(2), int'($urandom_range(6)) - 3,
                    int'($urandom_range(6)) - 3,
                    ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : ipd_pkg::MqttPubQ0,
                    $urandom_range(1), "");
      end else if (pick < 90) begin
        repeat ($urandom_range(6, 1)) begin
          line_q.push_back(($urandom_range(3) == 0) ? ipd_pkg::ChPlus : 8'($urandom_range(255)));
        end
      end else begin
        case ($urandom_range(4))
          0: put_str("+IPD,:");
          1: put_str("+IPD,0:");
          2: put_str("+IPD,5000");
          3: put_str("+IPD,12x");
          default: put_str("+IP+IPD,");
        endcase
      end
      send_line();
      if ($urandom_range(19) == 0) settle();
    end
  endtask

  task automatic test_directed_frames();
    add_publish(3, 4, 0, 0, 0, ipd_pkg::MqttPubQ0, 1'b0, "");
    add_publish(5, 0, 2, 0, 0, ipd_pkg::MqttPubQ0, 1'b0, "");
    add_publish(0, 0, 1, 0, 0, ipd_pkg::MqttPubQ0, 1'b0, "");
    add_publish(0, 6, 0, 0, 0, ipd_pkg::MqttPubQ0, 1'b0, "");
    add_publish(2, 2, 0, 0, 0, ipd_pkg::MqttPubQ0, 1'b1, "00");
    // header restarts on a stray plus, and a plus inside the length
    put_str("x+I+IP");
    add_publish(1, 1, 0, 0, 0, ipd_pkg::MqttPubQ0, 1'b0, "");
    put_str("+IPD,7");
    add_publish(1, 2, 0, 0, 0, ipd_pkg::MqttPubQ0, 1'b0, "");
    // oversize, boundary length without a frame, zero lengths
    put_str("+IPD,4097:+IPD,4096x+IPD,:+IPD,000:");
    add_publish(2, 2, 0, 0, 0, 8'h32, 1'b0, "");
    put_str("+IPD,1:");
    line_q.push_back(ipd_pkg::MqttPubQ0);
    put_str("+IPD,8:");
    line_q.push_back(ipd_pkg::MqttPubQ0);
    repeat (4) line_q.push_back(8'h80);
    line_q.push_back(8'hFF);
    line_q.push_back(8'h00);
    line_q.push_back(8'h7F);
    put_str("+IPD,2:");
    line_q.push_back(ipd_pkg::MqttPubQ0);
    line_q.push_back(8'h81);
    add_publish(0, 0, 0, 0, 0, ipd_pkg::MqttPubQ0, 1'b0, "");
    add_publish(4, 0, 0, 0, 0, ipd_pkg::MqttPubQ0, 1'b0, "");
    add_publish(2, 3, 0, 2, 0, ipd_pkg::MqttPubQ0, 1'b0, "");
    add_publish(2, 0, 1, -3, 0, ipd_pkg::MqttPubQ0, 1'b0, "");
    add_publish(1, 1, 3, 0, 0, ipd_pkg::MqttPubQ0, 1'b0, "");
    add_publish(2, 1, 0, 0, 0, ipd_pkg::MqttPubQ0, 1'b0, "");
    send_line();
  endtask

  task automatic test_limit_extremes();
    settle();
    write_limit(2'(ipd_pkg::CfgMaxTopic), 8'd0);
    write_limit(2'(ipd_pkg::CfgMaxPayload), 8'd0);
    add_publish(0, 0, 1, 0, 0, ipd_pkg::MqttPubQ0, 1'b0, "");
    add_publish(1, 0, 1, 0, 0, ipd_pkg::MqttPubQ0, 1'b0, "");
    add_publish(0, 1, 0, 0, 0, ipd_pkg::MqttPubQ0, 1'b0, "");
    send_line();
    settle();
    // unused indexes must leave both limits alone
    write_limit({1'b1, ipd_pkg::CfgMaxTopic}, 8'hFF);
    write_limit({1'b1, ipd_pkg::CfgMaxPayload}, 8'hFF);
    add_publish(1, 1, 0, 0, 0, ipd_pkg::MqttPubQ0, 1'b0, "");
    send_line();
    settle();
    write_limit(2'(ipd_pkg::CfgMaxTopic), 8'd64);
    write_limit(2'(ipd_pkg::CfgMaxPayload), 8'd128);
    add_publish(64, 128, 0, 0, 0, ipd_pkg::MqttPubQ0, 1'b0, "");
    add_publish(65, 1, 0, 0, 0, ipd_pkg::MqttPubQ0, 1'b0, "");
    add_publish(1, 129, 0, 0, 0, ipd_pkg::MqttPubQ0, 1'b0, "");
    send_line();
  endtask

  task automatic test_random_traffic();
    settle();
    write_limit(2'(ipd_pkg::CfgMaxTopic), 8'($urandom_range(64)));
    write_limit(2'(ipd_pkg::CfgMaxPayload), 8'($urandom_range(128)));
    random_burst(25);
    settle();
    write_limit(2'(ipd_pkg::CfgMaxTopic), 8'($urandom_range(4)));
    write_limit(2'(ipd_pkg::CfgMaxPayload), 8'($urandom_range(6)));
    random_burst(25);
    settle();
    write_limit(2'(ipd_pkg::CfgMaxTopic), 8'd64);
    write_limit(2'(ipd_pkg::CfgMaxPayload), 8'd128);
    random_burst(25);
    settle();
    write_limit(2'(ipd_pkg::CfgMaxTopic), 8'($urandom_range(12)));
    write_limit(2'(ipd_pkg::CfgMaxPayload), 8'($urandom_range(20)));
    random_burst(25);
  endtask

  task automatic test_no_idle();
    idling_on = 1'b0;
    random_burst(50);
    idling_on = 1'b1;
  endtask

  initial begin
    in_valid_i   = 1'b0;
    rx_byte_i    = '0;
    out_stall_i  = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    idling_on    = 1'b1;
    mismatches   = 0;
    stuck_cycles = 0;
    sent_bytes   = 0;
    lim_topic    = ipd_pkg::MaxTopicRst;
    lim_payload  = ipd_pkg::MaxPayloadRst;
    hdr_pos      = '0;
    phase        = PhHunt;
    flen         = '0;
    fpos         = '0;
    rem_len      = '0;
    vcnt         = '0;
    tlen_left    = '0;
    plen_left    = '0;
    rst_ni       = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_frames();
    test_limit_extremes();
    test_random_traffic();
    test_no_idle();

    settle();
    repeat (5) @(posedge clk_i);
    if (expected_beats.size() != 0) begin
      report("result beats still missing", expected_beats.size(), 0);
    end
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
